FILE: hdl/deqs_pkg.sv
// shared types and constants for the double-ended queue with search
package deqs_pkg;

  // operation codes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  // data returned by a pop on an empty queue
  localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;

  // input item
  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     found;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_POPD = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

endpackage

FILE: hdl/double_ended_queue_with_search.sv
// double-ended queue of signed words in a ring buffer, with a front-to-rear search
//
//   channel  ports                     handshake
//   input    start, busy, in_item      taken when start is high and busy is low
//   result   out_valid, out_item       one-cycle strobe, receiver cannot stall
//
// push: ram write in the exec state, then the registered result; pop: one ram read (exec, popd)
// search: a walk from the front over at most the n entries held, one ram read per entry
// through the single read port of the entry ram; a hit ends the walk early
// busy is high from the cycle after accept until the result strobe
// synchronous active-low reset clears front pointer and count; no clearing pass
module double_ended_queue_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  deqs_pkg::in_item_t  in_item,
  output logic                out_valid,
  output deqs_pkg::out_item_t out_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  deqs_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [deqs_pkg::DATA_W-1:0] key_r, key_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic                out_valid_r, out_valid_nxt;
  deqs_pkg::out_item_t out_item_r, out_item_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [deqs_pkg::DATA_W-1:0] ram_rdata;

  logic                q_full;
  logic                q_empty;
  logic [CW-1:0]       ring_off;
  logic [SW-1:0]       ring_sum;
  logic [AW-1:0]       ring_pos;
  logic [AW-1:0]       front_inc;
  logic [AW-1:0]       front_dec;
  logic [AW-1:0]       ptr_inc;
  logic [CW-1:0]       count_inc;
  logic [CW-1:0]       count_dec;

  // entry storage
  deqs_ram #(
    .WIDTH(deqs_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(key_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // occupancy flags
  assign q_full  = (count_r == CW'(DEPTH));
  assign q_empty = (count_r == '0);
  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  // ring position of the rear slot (push rear) or the last entry (pop rear)
  assign ring_off = (op_r == deqs_pkg::OP_PUSH_REAR) ? count_r : count_dec;
  assign ring_sum = SW'(front_r) + SW'(ring_off);
  assign ring_pos = (ring_sum >= SW'(DEPTH)) ? AW'(ring_sum - SW'(DEPTH)) : AW'(ring_sum);

  // wrapping pointer steps
  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;
  assign ptr_inc   = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    ptr_nxt       = ptr_r;
    scan_nxt      = scan_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ring_pos;
    ram_raddr     = ptr_r;

    out_item_nxt           = '0;
    out_item_nxt.status    = deqs_pkg::STAT_OK;
    out_item_nxt.occupancy = deqs_pkg::OCC_W'(count_r);

    unique case (state_r)
      deqs_pkg::S_IDLE: begin
        if (start) begin
          op_nxt    = in_item.op;
          key_nxt   = in_item.value;
          state_nxt = deqs_pkg::S_EXEC;
        end
      end

      deqs_pkg::S_EXEC: begin
        unique case (op_r)
          deqs_pkg::OP_PUSH_FRONT: begin
            out_valid_nxt = 1'b1;
            state_nxt     = deqs_pkg::S_IDLE;
            if (q_full) begin
              out_item_nxt.status = deqs_pkg::STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = front_dec;
              front_nxt = front_dec;
              count_nxt = count_inc;
              out_item_nxt.occupancy = deqs_pkg::OCC_W'(count_inc);
            end
          end

          deqs_pkg::OP_PUSH_REAR: begin
            out_valid_nxt = 1'b1;
            state_nxt     = deqs_pkg::S_IDLE;
            if (q_full) begin
              out_item_nxt.status = deqs_pkg::STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_inc;
              out_item_nxt.occupancy = deqs_pkg::OCC_W'(count_inc);
            end
          end

          deqs_pkg::OP_POP_FRONT, deqs_pkg::OP_POP_REAR: begin
            if (q_empty) begin
              out_item_nxt.data_out = deqs_pkg::EMPTY_DATA;
              out_item_nxt.status   = deqs_pkg::STAT_EMPTY;
              out_valid_nxt = 1'b1;
              state_nxt     = deqs_pkg::S_IDLE;
            end else begin
              ram_raddr = (op_r == deqs_pkg::OP_POP_FRONT) ? front_r : ring_pos;
              state_nxt = deqs_pkg::S_POPD;
            end
          end

          deqs_pkg::OP_SEARCH: begin
            if (q_empty) begin
              out_valid_nxt = 1'b1;
              state_nxt     = deqs_pkg::S_IDLE;
            end else begin
              ram_raddr = front_r;
              ptr_nxt   = front_inc;
              scan_nxt  = CW'(1);
              state_nxt = deqs_pkg::S_SCAN;
            end
          end

          default: begin
            // unused codes: no operation
            out_valid_nxt = 1'b1;
            state_nxt     = deqs_pkg::S_IDLE;
          end
        endcase
      end

      // read data is back: finish the pop
      deqs_pkg::S_POPD: begin
        out_item_nxt.data_out  = ram_rdata;
        out_item_nxt.occupancy = deqs_pkg::OCC_W'(count_dec);
        count_nxt     = count_dec;
        out_valid_nxt = 1'b1;
        state_nxt     = deqs_pkg::S_IDLE;
        if (op_r == deqs_pkg::OP_POP_FRONT) begin
          front_nxt = front_inc;
        end
      end

      // compare the entry read last cycle, issue the next read
      deqs_pkg::S_SCAN: begin
        if (ram_rdata == key_r) begin
          out_item_nxt.found = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = deqs_pkg::S_IDLE;
        end else if (scan_r == count_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = deqs_pkg::S_IDLE;
        end else begin
          ram_raddr = ptr_r;
          ptr_nxt   = ptr_inc;
          scan_nxt  = scan_r + 1'b1;
        end
      end

      default: begin
        state_nxt = deqs_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deqs_pkg::S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    ptr_r      <= ptr_nxt;
    scan_r     <= scan_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != deqs_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hdl/deqs_ram.sv
// generic single-write, single-read ram with registered read data
module deqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sim/tb_double_ended_queue_with_search.sv
// self-checking testbench for the double-ended queue with search
`timescale 1ns / 1ps

module tb_double_ended_queue_with_search;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned ITEMS_PER_PHASE = 317;

  // operation codes the block treats as no operation
  localparam logic [2:0] OP_UNUSED_A = 3'd5;
  localparam logic [2:0] OP_UNUSED_B = 3'd6;
  localparam logic [2:0] OP_UNUSED_C = 3'd7;

  // mix of operations in the random part
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_t;

  // tracks queue contents and the results they imply
  class deque_tracker;
    logic signed [deqs_pkg::DATA_W-1:0] ring[RING_DEPTH];
    int unsigned                        head;
    int unsigned                        count;
    deqs_pkg::out_item_t                expected_results[$];
    int unsigned                        errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // word at a given distance from the front
    function logic signed [deqs_pkg::DATA_W-1:0] held_word(int unsigned offset);
      return ring[(head + offset) % RING_DEPTH];
    endfunction

    // apply one accepted item and queue the result it must produce
    function void take_item(deqs_pkg::in_item_t it);
      deqs_pkg::out_item_t res;
      res        = '0;
      res.status = deqs_pkg::STAT_OK;
      unique case (it.op)
        deqs_pkg::OP_PUSH_FRONT: begin
          if (count >= RING_DEPTH) begin
            res.status = deqs_pkg::STAT_FULL;
          end else begin
            head       = (head + RING_DEPTH - 1) % RING_DEPTH;
            ring[head] = it.value;
            count++;
          end
        end
        deqs_pkg::OP_PUSH_REAR: begin
          if (count >= RING_DEPTH) begin
            res.status = deqs_pkg::STAT_FULL;
          end else begin
            ring[(head + count) % RING_DEPTH] = it.value;
            count++;
          end
        end
        deqs_pkg::OP_POP_FRONT: begin
          if (count == 0) begin
            res.data_out = deqs_pkg::EMPTY_DATA;
            res.status   = deqs_pkg::STAT_EMPTY;
          end else begin
            res.data_out = ring[head];
            head         = (head + 1) % RING_DEPTH;
            count--;
          end
        end
        deqs_pkg::OP_POP_REAR: begin
          if (count == 0) begin
            res.data_out = deqs_pkg::EMPTY_DATA;
            res.status   = deqs_pkg::STAT_EMPTY;
          end else begin
            res.data_out = held_word(count - 1);
            count--;
          end
        end
        deqs_pkg::OP_SEARCH: begin
          for (int unsigned i = 0; i < count; i++) begin
            if (held_word(i) == it.value) res.found = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.occupancy = deqs_pkg::OCC_W'(count);
      expected_results.push_back(res);
    endfunction

    function void report(string field, longint exp_val, longint act_val);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d",
               $time, field, exp_val, act_val);
    endfunction

    // compare one result with the oldest outstanding expectation
    function void check_result(deqs_pkg::out_item_t got);
      deqs_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.data_out !== want.data_out) report("data_out", want.data_out, got.data_out);
      if (got.found !== want.found) report("found", want.found, got.found);
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.occupancy !== want.occupancy) report("occupancy", want.occupancy, got.occupancy);
    endfunction
  endclass

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  deqs_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  deqs_pkg::out_item_t out_item;

  deque_tracker tracker = new();
  int unsigned  stall_cycles = 0;

  double_ended_queue_with_search #(
    .DEPTH(RING_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_item);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(deqs_pkg::in_item_t it);
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.take_item(it);
  endtask

  task automatic send_op(logic [2:0] op, logic signed [deqs_pkg::DATA_W-1:0] value);
    deqs_pkg::in_item_t it;
    it.op    = op;
    it.value = value;
    send_item(it);
  endtask

  // sender gap: idle cycles with junk on the item bus
  task automatic sender_gap(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start   <= 1'b0;
      in_item <= deqs_pkg::in_item_t'({$urandom, $urandom});
      @(posedge clk);
      while ($urandom_range(99) < pct) @(posedge clk);
    end
  endtask

  // stop sending until every outstanding result is back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [deqs_pkg::DATA_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return 32'sh7fff_ffff;
    if (r < 6) return 32'sh8000_0000;
    if (r < 8) return -32'sd1;
    if (r < 10) return 32'sd0;
    if (r < 40) return $urandom_range(15);
    return $urandom;
  endfunction

  function automatic deqs_pkg::in_item_t random_item(op_mix_t mix);
    deqs_pkg::in_item_t it;
    int unsigned        r;
    int unsigned        push_pct;
    r        = $urandom_range(99);
    push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
    it.value = pick_word();
    if (r < 3) begin
      it.op = 3'($urandom_range(OP_UNUSED_C, OP_UNUSED_A));
    end else if (r < 23) begin
      it.op = deqs_pkg::OP_SEARCH;
      // half the time look for something actually held
      if (tracker.count != 0 && $urandom_range(1) == 1)
        it.value = tracker.held_word($urandom_range(tracker.count - 1));
    end else if ($urandom_range(99) < push_pct) begin
      it.op = $urandom_range(1) ? deqs_pkg::OP_PUSH_REAR : deqs_pkg::OP_PUSH_FRONT;
    end else begin
      it.op = $urandom_range(1) ? deqs_pkg::OP_POP_REAR : deqs_pkg::OP_POP_FRONT;
    end
    return it;
  endfunction

  // stimulus
  initial begin
    int unsigned idle_pct;
    op_mix_t     mix;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, unused codes, extremes, hits and misses at both ends
    send_op(deqs_pkg::OP_POP_FRONT, 32'sd0);
    send_op(deqs_pkg::OP_POP_REAR, 32'sd0);
    send_op(deqs_pkg::OP_SEARCH, 32'sd0);
    send_op(OP_UNUSED_A, $urandom);
    send_op(OP_UNUSED_B, $urandom);
    send_op(OP_UNUSED_C, $urandom);
    send_op(deqs_pkg::OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_op(deqs_pkg::OP_PUSH_REAR, 32'sh8000_0000);
    send_op(deqs_pkg::OP_PUSH_FRONT, -32'sd1);
    send_op(deqs_pkg::OP_PUSH_REAR, 32'sd0);
    send_op(OP_UNUSED_A, 32'sd0);
    send_op(deqs_pkg::OP_SEARCH, -32'sd1);
    send_op(deqs_pkg::OP_SEARCH, 32'sd0);
    send_op(deqs_pkg::OP_SEARCH, 32'sh7fff_ffff);
    send_op(deqs_pkg::OP_SEARCH, 32'sh8000_0000);
    send_op(deqs_pkg::OP_SEARCH, 32'sd12345);
    send_op(deqs_pkg::OP_POP_FRONT, 32'sd0);
    send_op(deqs_pkg::OP_POP_REAR, 32'sd0);
    send_op(deqs_pkg::OP_POP_FRONT, 32'sd0);
    send_op(deqs_pkg::OP_POP_REAR, 32'sd0);
    send_op(deqs_pkg::OP_POP_REAR, 32'sd0);
    send_op(deqs_pkg::OP_SEARCH, -32'sd1);
    wait_drained();

    // random: sender idle 34%, then 56%, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 34 : (phase == 1) ? 56 : 0;
      mix      = MIX_FILL;
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 24 == 0) mix = op_mix_t'($urandom_range(2));
        sender_gap(idle_pct);
        send_item(random_item(mix));
      end
      wait_drained();
    end

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: double_ended_queue_with_search.f
hdl/deqs_pkg.sv
hdl/deqs_ram.sv
hdl/double_ended_queue_with_search.sv
sim/tb_double_ended_queue_with_search.sv
